// ===== rtl/msar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msar_pkg
// Shared constants and types for the max-subarray-after-removals block.
// ----------------------------------------------------------------------------
package msar_pkg;

    localparam int DEPTH  = 1024;
    localparam int NCELL  = 8;
    localparam int SEG    = DEPTH / NCELL;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CELL_W = $clog2(NCELL);
    localparam int SEG_W  = $clog2(SEG);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 41;

    localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(DEPTH);
    localparam logic [LEN_W-1:0] LENGTH_MAX   = LEN_W'(DEPTH);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // table write, broadcast to every cell
    typedef struct packed {
        logic              val_we;
        logic              rem_we;
        logic              rem_all;
        logic [CELL_W-1:0] bank;
        logic [SEG_W-1:0]  addr;
        logic [VAL_W-1:0]  value;
        logic              rem;
    } msar_wr_t;

    // scan position, broadcast to every cell
    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] bank;
        logic [SEG_W-1:0]  addr;
        logic              first;
        logic              live;
    } msar_scan_t;

    // running sums handed from cell to cell
    typedef struct packed {
        logic [SUM_W-1:0] cur;
        logic [SUM_W-1:0] best;
    } msar_run_t;

endpackage

// ===== rtl/msar_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msar_cell
// One segment of the table with its own value and removed-flag memories,
// and a running-sum update that takes over from the previous cell.
// ----------------------------------------------------------------------------
module msar_cell
    import msar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CELL_W-1:0] cell_id,
    input  msar_wr_t          wr,
    input  msar_scan_t        scan,
    input  msar_run_t         run_in,
    output msar_run_t         run_out
);

    logic [VAL_W-1:0] val_mem [SEG];
    logic             rem_mem [SEG];

    logic [VAL_W-1:0] val_q_reg;
    logic             rem_q_reg;
    logic             act_reg;
    logic             first_reg;
    logic             live_reg;
    logic [SUM_W-1:0] cur_reg;
    logic [SUM_W-1:0] best_reg;

    logic             wr_hit;
    logic [SUM_W-1:0] base_cur;
    logic [SUM_W-1:0] base_best;
    logic [SUM_W+1:0] sum;
    logic [SUM_W-1:0] cur_next;
    logic [SUM_W-1:0] best_next;

    assign wr_hit = (wr.bank == cell_id);

    always_ff @(posedge clk)
    begin
        if (wr.val_we && wr_hit)
        begin
            val_mem[wr.addr] <= wr.value;
        end
        if (wr.rem_we && (wr.rem_all || wr_hit))
        begin
            rem_mem[wr.addr] <= wr.rem;
        end
        val_q_reg <= val_mem[scan.addr];
        rem_q_reg <= rem_mem[scan.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= 1'b0;
            first_reg <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            act_reg   <= scan.valid && (scan.bank == cell_id);
            first_reg <= scan.first;
            live_reg  <= scan.live;
        end
    end

    always_comb
    begin
        base_cur  = first_reg ? run_in.cur  : cur_reg;
        base_best = first_reg ? run_in.best : best_reg;
        sum = {2'b00, base_cur}
            + {{(SUM_W + 2 - VAL_W){val_q_reg[VAL_W-1]}}, val_q_reg};
        if (!live_reg)
        begin
            cur_next = base_cur;
        end
        else if (rem_q_reg || sum[SUM_W+1])
        begin
            // a removed entry breaks the run, a negative run restarts empty
            cur_next = '0;
        end
        else
        begin
            cur_next = sum[SUM_W-1:0];
        end
        best_next = (cur_next > base_best) ? cur_next : base_best;
    end

    always_ff @(posedge clk)
    begin
        if (act_reg)
        begin
            cur_reg  <= cur_next;
            best_reg <= best_next;
        end
    end

    assign run_out.cur  = cur_reg;
    assign run_out.best = best_reg;

endmodule

// ===== rtl/msar_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msar_ctrl
// Sequencer: flag clearing after reset, table writes, the entry-by-entry
// scan and the result register.
// ----------------------------------------------------------------------------
module msar_ctrl
    import msar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [ADDR_W-1:0] index,
    input  logic [VAL_W-1:0]  value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SUM_W-1:0]  max_sum,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_wdata,
    output msar_wr_t          wr,
    output msar_scan_t        scan,
    input  msar_run_t         run_last
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [LEN_W-1:0]  length_reg;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  max_sum_reg;

    logic              accept;
    logic              clearing;
    logic              out_free;
    logic [LEN_W-1:0]  len_eff;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign clearing  = (state_reg == ST_CLEAR);
    assign out_free  = !out_valid_reg || out_ready;
    assign len_eff   = (length_reg > LENGTH_MAX) ? LENGTH_MAX : length_reg;
    assign out_valid = out_valid_reg;
    assign max_sum   = max_sum_reg;

    always_comb
    begin
        wr.val_we  = accept && (operation == OP_LOAD);
        wr.rem_we  = accept || clearing;
        wr.rem_all = clearing;
        wr.bank    = index[ADDR_W-1:SEG_W];
        wr.addr    = clearing ? pos_reg[SEG_W-1:0] : index[SEG_W-1:0];
        wr.value   = value;
        wr.rem     = !clearing && (operation == OP_REMOVE);

        scan.valid = (state_reg == ST_SCAN);
        scan.bank  = pos_reg[ADDR_W-1:SEG_W];
        scan.addr  = pos_reg[SEG_W-1:0];
        scan.first = (pos_reg[SEG_W-1:0] == '0);
        scan.live  = ({1'b0, pos_reg} < len_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pos_reg       <= '0;
            length_reg    <= LENGTH_RESET;
            out_valid_reg <= 1'b0;
            max_sum_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                length_reg <= cfg_wdata;
            end

            // in the finish state the result register is loaded instead
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    // all banks are cleared side by side
                    if (pos_reg[SEG_W-1:0] == SEG_W'(SEG - 1))
                    begin
                        pos_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && (operation == OP_REMOVE))
                    begin
                        pos_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH:
                begin
                    // last entry is still in the read and update stages
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        max_sum_reg   <= run_last.best;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/max_subarray_after_removals.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_subarray_after_removals
// Largest contiguous sum over a table of values with removable entries.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready) carries operation, index and value.
// A load writes the value at index and clears its removed flag; it gives no
// result. A removal marks the entry and starts a scan of the whole table,
// one entry per cycle, through a row of eight cells that each own one
// segment of the table and hand the running sums on to the next. The
// result leaves on the output channel (out_valid / out_ready) once the scan
// has stepped over every entry, a flush step has passed and the result
// register is loaded; in_ready returns with it. The running sum takes one
// entry per cycle. in_ready stays low while a scan runs.
// After reset the removed flags are cleared, all segments at once; in_ready
// is low meanwhile and length returns to 1024. cfg_we writes length; the
// user must do so only while the block is idle, which it does not enforce.
// A finished result waits in the output register while the receiver stalls;
// loads are still taken, and a following scan holds its result until the
// register is free.
// ----------------------------------------------------------------------------
module max_subarray_after_removals
    import msar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [ADDR_W-1:0] index,
    input  logic [VAL_W-1:0]  value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SUM_W-1:0]  max_sum,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_wdata
);

    msar_wr_t   wr;
    msar_scan_t scan;
    msar_run_t  chain [NCELL+1];

    assign chain[0] = '0;

    msar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .max_sum   (max_sum),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .wr        (wr),
        .scan      (scan),
        .run_last  (chain[NCELL])
    );

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        msar_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (CELL_W'(i)),
            .wr      (wr),
            .scan    (scan),
            .run_in  (chain[i]),
            .run_out (chain[i+1])
        );
    end

endmodule

// ===== rtl/msar_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msar_checker
// Port-level checks on the max-subarray-after-removals block.
// ----------------------------------------------------------------------------
module msar_checker
    import msar_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              operation,
    input logic              out_valid,
    input logic              out_ready,
    input logic [SUM_W-1:0]  max_sum
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(max_sum)))
        else $error("result changed while stalled");

    // a removal transfer starts a scan
    a_remove_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == OP_REMOVE)) |=> !in_ready)
        else $error("input taken during scan");

    // a load does not block the next transfer
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == OP_LOAD)) |=> in_ready)
        else $error("load stalled the input");

    // a new result only follows a busy period
    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a scan");

endmodule

bind max_subarray_after_removals msar_checker u_msar_checker (.*);

// ===== test/msar_sum_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msar_sum_checker
// Watches the input, output and configuration ports of the max-subarray
// block. It keeps its own copy of the table and of length, works out the best
// run sum for every removal, and compares each result transfer with the
// oldest outstanding sum.
// ----------------------------------------------------------------------------
module msar_sum_checker
    import msar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              operation,
    input  logic [ADDR_W-1:0] index,
    input  logic [VAL_W-1:0]  value,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [SUM_W-1:0]  max_sum,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_wdata,
    output int                mismatches,
    output int                pending
);

    logic [VAL_W-1:0] cell_value [DEPTH];
    bit               cell_gone  [DEPTH];
    logic [LEN_W-1:0] run_length;
    logic [SUM_W-1:0] sum_queue  [$];
    logic [SUM_W-1:0] want_sum;

    // running best over the covered entries; a removed entry breaks the run
    function automatic logic [SUM_W-1:0] best_run_sum();
        longint cur;
        longint best;
        int     span;
        int     i;
        cur  = 0;
        best = 0;
        span = (run_length > LENGTH_MAX) ? DEPTH : int'(run_length);
        for (i = 0; i < span; i++)
        begin
            if (cell_gone[i])
                cur = 0;
            else
            begin
                cur = cur + longint'($signed(cell_value[i]));
                if (cur < 0)
                    cur = 0;
                if (cur > best)
                    best = cur;
            end
        end
        return best[SUM_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [SUM_W-1:0] want,
                                   input logic [SUM_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected max_sum %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                cell_gone[k] = 1'b0;
            run_length = LENGTH_RESET;
            sum_queue.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            // result side first: it can only belong to an earlier removal
            if (out_valid && out_ready)
            begin
                if (sum_queue.size() == 0)
                    report_mismatch("result with nothing outstanding", '0, max_sum);
                else
                begin
                    want_sum = sum_queue.pop_front();
                    if (max_sum !== want_sum)
                        report_mismatch("wrong max_sum", want_sum, max_sum);
                end
            end
            if (cfg_we)
                run_length = cfg_wdata;
            if (in_valid && in_ready)
            begin
                if (operation == OP_LOAD)
                begin
                    cell_value[index] = value;
                    cell_gone[index]  = 1'b0;
                end
                else
                begin
                    cell_gone[index] = 1'b1;
                    sum_queue.push_back(best_run_sum());
                end
            end
            pending = sum_queue.size();
        end
    end

endmodule

// ===== test/max_subarray_after_removals_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_subarray_after_removals_tb
// Drives loads and removals into the block with random gaps on both sides,
// steps length through a range of settings between phases, and leaves the
// checking to msar_sum_checker. Removals are only issued once every entry
// the search covers has been loaded or removed.
// ----------------------------------------------------------------------------
module max_subarray_after_removals_tb;
    import msar_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              operation;
    logic [ADDR_W-1:0] index;
    logic [VAL_W-1:0]  value;
    logic              out_valid;
    logic              out_ready;
    logic [SUM_W-1:0]  max_sum;
    logic              cfg_we;
    logic [LEN_W-1:0]  cfg_wdata;

    int mismatches;
    int pending;

    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    bit known [DEPTH];
    int cur_length   = DEPTH;

    always #1 clk = ~clk;

    max_subarray_after_removals dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .max_sum   (max_sum),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    msar_sum_checker sum_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .max_sum    (max_sum),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin : time_limit
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (3000) @(negedge clk);
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    function automatic int window();
        return (cur_length > DEPTH) ? DEPTH : cur_length;
    endfunction

    // lowest covered entry that is neither loaded nor removed, or -1
    function automatic int first_unknown();
        int i;
        for (i = 0; i < window(); i++)
            if (!known[i])
                return i;
        return -1;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return VAL_W'($urandom_range(160)) - VAL_W'(60);
            4:          return 32'h7fff_ffff;
            5:          return 32'h8000_0000;
            default:    return VAL_W'($urandom());
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send(input logic op, input int idx, input logic [VAL_W-1:0] val);
        while (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        index     <= idx[ADDR_W-1:0];
        value     <= val;
        known[idx] = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // only while idle: every result in, then a wait so that a trailing load lands
    task automatic set_length(input int len);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len[LEN_W-1:0];
        cur_length = len;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        int idx;
        int gap;
        gap = first_unknown();
        if ($urandom_range(99) < 25)
        begin
            if (gap >= 0)
                send(OP_LOAD, gap, rand_value());
            else
            begin
                if (window() > 0 && $urandom_range(99) < 80)
                    idx = $urandom_range(window() - 1);
                else
                    idx = $urandom_range(DEPTH - 1);
                send(OP_REMOVE, idx, VAL_W'($urandom()));
            end
        end
        else
        begin
            if (window() > 0 && $urandom_range(99) < 75)
                idx = $urandom_range(window() - 1);
            else
                idx = $urandom_range(DEPTH - 1);
            send(OP_LOAD, idx, rand_value());
        end
    endtask

    initial
    begin : stimulus
        int gap;
        int len;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_LOAD;
        index     = '0;
        value     = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // flag clearing pass after reset
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);

        set_length(1);
        send(OP_LOAD, 0, 32'h7fff_ffff);
        send(OP_REMOVE, 1023, '0);             // beyond length, still marked
        send(OP_LOAD, 1, 32'h8000_0000);
        send(OP_REMOVE, 1, 32'hffff_ffff);     // value is ignored on removal
        send(OP_LOAD, 0, 32'h8000_0000);
        send(OP_REMOVE, 2, '0);                // negative run clamps to zero
        set_length(0);
        send(OP_REMOVE, 0, '0);                // empty search
        set_length(4);
        send(OP_LOAD, 0, 32'h7fff_ffff);
        send(OP_LOAD, 1, 32'h7fff_ffff);
        send(OP_LOAD, 2, 32'hffff_ffff);
        send(OP_LOAD, 3, 32'h7fff_ffff);
        send(OP_REMOVE, 3, '0);
        send(OP_LOAD, 3, 32'h7fff_ffff);       // reload clears the flag
        send(OP_REMOVE, 2, '0);
        send(OP_REMOVE, 2, '0);                // removing twice changes nothing
        send(OP_LOAD, 2, 32'h0000_0001);
        send(OP_REMOVE, 1023, '0);

        // mostly short windows so that the table fills a little at a time
        for (int p = 0; p < 10; p++)
        begin
            case (p % 4)
                0:       len = $urandom_range(8, 1);
                1:       len = $urandom_range(24, 3);
                2:       len = $urandom_range(64, 25);
                default: len = $urandom_range(160, 65);
            endcase
            calm = (p == 3);
            set_length(len);
            // the covered entries are filled, then the input stalls behind the held result
            if (p == 6)
            begin
                gap = first_unknown();
                while (gap >= 0)
                begin
                    send(OP_LOAD, gap, rand_value());
                    gap = first_unknown();
                end
                hold_request = 1'b1;
                repeat (3) send(OP_REMOVE, $urandom_range(window() - 1), '0);
            end
            repeat (52) random_item();
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
